/* rtl/hse_pkg.sv */
// shared types and constants for the heap sort engine
`timescale 1ns / 1ps

package hse_pkg;

    localparam int DATA_W            = 32;
    localparam int DEFAULT_MAX_ITEMS = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B_RD,
        ST_B_CAP,
        ST_SIFT_CHK,
        ST_SIFT_L,
        ST_SIFT_R,
        ST_X_RDI,
        ST_X_RD0,
        ST_X_WR,
        ST_OUT
    } state_t;

endpackage

/* rtl/hse_mem.sv */
// element store: one write port, one read port, registered read data
`timescale 1ns / 1ps

module hse_mem #(
    parameter int DEPTH = hse_pkg::DEFAULT_MAX_ITEMS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [hse_pkg::DATA_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [hse_pkg::DATA_W-1:0] rdata
);

    logic [hse_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/hse_ctrl.sv */
// sequencer: loads the set, builds the heap, sorts in place and streams results
`timescale 1ns / 1ps

module hse_ctrl #(
    parameter int MAX_ITEMS = hse_pkg::DEFAULT_MAX_ITEMS,
    parameter int AW        = $clog2(MAX_ITEMS),
    parameter int CW        = $clog2(MAX_ITEMS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [hse_pkg::DATA_W-1:0] value,
    input  logic                        last,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [hse_pkg::DATA_W-1:0]  mem_wdata,
    output logic                        mem_re,
    output logic [AW-1:0]               mem_raddr,
    input  logic [hse_pkg::DATA_W-1:0]  mem_rdata,
    output logic                        result_valid,
    output logic                        final_res,
    output logic                        overflow
);

    hse_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_seen_reg, ovf_seen_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [AW-1:0] lim_reg, lim_next;
    logic [AW-1:0] p_reg, p_next;
    logic [AW-1:0] k_reg, k_next;
    logic          sort_reg, sort_next;
    logic          strobe_reg, strobe_next;
    logic          final_reg, final_next;
    logic          ovf_out_reg, ovf_out_next;
    logic [hse_pkg::DATA_W-1:0] pv_reg, pv_next;
    logic [hse_pkg::DATA_W-1:0] lv_reg, lv_next;

    logic [AW+1:0]              cl;
    logic [AW+1:0]              cr;
    logic [AW+1:0]              lim_ext;
    logic                       pick_r;
    logic [hse_pkg::DATA_W-1:0] cand_val;
    logic [AW-1:0]              cand_addr;
    logic                       sink;
    logic                       sift_end;
    logic                       full;
    logic [CW-1:0]              cnt_after;

    assign cl        = {1'b0, p_reg, 1'b1};
    assign cr        = cl + (AW+2)'(1);
    assign lim_ext   = {2'b00, lim_reg};
    assign pick_r    = (state_reg == hse_pkg::ST_SIFT_R) &&
                       ($signed(lv_reg) < $signed(mem_rdata));
    assign cand_val  = ((state_reg == hse_pkg::ST_SIFT_R) && !pick_r) ? lv_reg : mem_rdata;
    assign cand_addr = pick_r ? cr[AW-1:0] : cl[AW-1:0];
    assign sink      = $signed(pv_reg) < $signed(cand_val);
    assign full      = (count_reg == CW'(MAX_ITEMS));
    assign cnt_after = full ? count_reg : count_reg + CW'(1);

    assign busy         = (state_reg != hse_pkg::ST_IDLE);
    assign result_valid = strobe_reg;
    assign final_res    = final_reg;
    assign overflow     = ovf_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hse_pkg::ST_IDLE;
            count_reg    <= '0;
            ovf_seen_reg <= 1'b0;
            strobe_reg   <= 1'b0;
            sort_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_seen_reg <= ovf_seen_next;
            strobe_reg   <= strobe_next;
            sort_reg     <= sort_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        i_reg       <= i_next;
        lim_reg     <= lim_next;
        p_reg       <= p_next;
        k_reg       <= k_next;
        final_reg   <= final_next;
        ovf_out_reg <= ovf_out_next;
        pv_reg      <= pv_next;
        lv_reg      <= lv_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_seen_next = ovf_seen_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        lim_next      = lim_reg;
        p_next        = p_reg;
        k_next        = k_reg;
        sort_next     = sort_reg;
        strobe_next   = 1'b0;
        final_next    = final_reg;
        ovf_out_next  = ovf_out_reg;
        pv_next       = pv_reg;
        lv_next       = lv_reg;
        mem_we        = 1'b0;
        mem_waddr     = p_reg;
        mem_wdata     = pv_reg;
        mem_re        = 1'b0;
        mem_raddr     = cl[AW-1:0];
        sift_end      = 1'b0;

        case (state_reg)
            hse_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (!full)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        mem_wdata  = value;
                        count_next = cnt_after;
                    end
                    else
                    begin
                        ovf_seen_next = 1'b1;
                    end
                    if (last)
                    begin
                        ovf_out_next  = ovf_seen_reg | full;
                        count_next    = '0;
                        ovf_seen_next = 1'b0;
                        n_next        = cnt_after;
                        lim_next      = AW'(cnt_after - CW'(1));
                        sort_next     = 1'b0;
                        k_next        = '0;
                        i_next        = cnt_after >> 1;
                        if (cnt_after < CW'(2))
                        begin
                            state_next = hse_pkg::ST_OUT;
                        end
                        else
                        begin
                            state_next = hse_pkg::ST_B_RD;
                        end
                    end
                end
            end

            // build phase: fetch the subtree root
            hse_pkg::ST_B_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(i_reg - CW'(1));
                p_next     = AW'(i_reg - CW'(1));
                state_next = hse_pkg::ST_B_CAP;
            end

            hse_pkg::ST_B_CAP:
            begin
                pv_next    = mem_rdata;
                state_next = hse_pkg::ST_SIFT_CHK;
            end

            // hole at p, pending value in pv
            hse_pkg::ST_SIFT_CHK:
            begin
                if (cl > lim_ext)
                begin
                    mem_we   = 1'b1;
                    sift_end = 1'b1;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = cl[AW-1:0];
                    state_next = hse_pkg::ST_SIFT_L;
                end
            end

            hse_pkg::ST_SIFT_L:
            begin
                lv_next = mem_rdata;
                if (cr <= lim_ext)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = cr[AW-1:0];
                    state_next = hse_pkg::ST_SIFT_R;
                end
                else if (sink)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = cand_val;
                    p_next     = cand_addr;
                    state_next = hse_pkg::ST_SIFT_CHK;
                end
                else
                begin
                    mem_we   = 1'b1;
                    sift_end = 1'b1;
                end
            end

            hse_pkg::ST_SIFT_R:
            begin
                if (sink)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = cand_val;
                    p_next     = cand_addr;
                    state_next = hse_pkg::ST_SIFT_CHK;
                end
                else
                begin
                    mem_we   = 1'b1;
                    sift_end = 1'b1;
                end
            end

            // sort phase: root swaps with the heap end
            hse_pkg::ST_X_RDI:
            begin
                mem_re     = 1'b1;
                mem_raddr  = i_reg[AW-1:0];
                state_next = hse_pkg::ST_X_RD0;
            end

            hse_pkg::ST_X_RD0:
            begin
                pv_next    = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = hse_pkg::ST_X_WR;
            end

            hse_pkg::ST_X_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = i_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                p_next     = '0;
                lim_next   = AW'(i_reg - CW'(1));
                state_next = hse_pkg::ST_SIFT_CHK;
            end

            hse_pkg::ST_OUT:
            begin
                mem_re      = 1'b1;
                mem_raddr   = k_reg;
                strobe_next = 1'b1;
                final_next  = (CW'(k_reg) == (n_reg - CW'(1)));
                k_next      = k_reg + AW'(1);
                if (CW'(k_reg) == (n_reg - CW'(1)))
                begin
                    state_next = hse_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = hse_pkg::ST_IDLE;
            end
        endcase

        if (sift_end)
        begin
            k_next = '0;
            if (i_reg == CW'(1))
            begin
                if (sort_reg)
                begin
                    state_next = hse_pkg::ST_OUT;
                end
                else
                begin
                    sort_next  = 1'b1;
                    i_next     = n_reg - CW'(1);
                    state_next = hse_pkg::ST_X_RDI;
                end
            end
            else
            begin
                i_next     = i_reg - CW'(1);
                state_next = sort_reg ? hse_pkg::ST_X_RDI : hse_pkg::ST_B_RD;
            end
        end
    end

endmodule

/* rtl/heap_sort_engine.sv */
// top level of the heap sort engine: sequencer and element store
`timescale 1ns / 1ps

// Values are loaded one per request while busy is low; the request with
// last set closes the set, and busy then stays high until the sorted values
// have been sent. Each sift-down moves one heap level at a time, bounded by
// the single read port of the element store; sorting is followed by one
// result per cycle. Results come out in ascending order, each valid for
// exactly one cycle on result_valid, and the receiver cannot hold them off.
// final_res marks the last one; overflow is set on every result of a set
// from which values beyond MAX_ITEMS were dropped.
module heap_sort_engine #(
    parameter int MAX_ITEMS = hse_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [hse_pkg::DATA_W-1:0] value,
    input  logic                              last,
    output logic                              result_valid,
    output logic signed [hse_pkg::DATA_W-1:0] sorted_value,
    output logic                              final_res,
    output logic                              overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [hse_pkg::DATA_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic [hse_pkg::DATA_W-1:0] mem_rdata;

    hse_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .result_valid (result_valid),
        .final_res    (final_res),
        .overflow     (overflow)
    );

    hse_mem #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign sorted_value = $signed(mem_rdata);

endmodule

/* tb/tb.sv */
// self-checking testbench for the heap sort engine: table-driven and random sets
`timescale 1ns / 1ps

module tb;

    localparam int DW          = hse_pkg::DATA_W;
    localparam int STORE_DEPTH = hse_pkg::DEFAULT_MAX_ITEMS;

    localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};

    typedef struct packed {
        logic signed [DW-1:0] sorted_value;
        logic                 final_res;
        logic                 overflow;
    } sorted_result_t;

    typedef struct packed {
        logic signed [DW-1:0] v;
        logic                 l;
        logic                 pinned;
        logic signed [DW-1:0] exp_v;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [DW-1:0] value;
    logic                 last;
    logic                 result_valid;
    logic signed [DW-1:0] sorted_value;
    logic                 final_res;
    logic                 overflow;

    logic                 busy_seen;

    logic signed [DW-1:0] set_vals [STORE_DEPTH];
    int                   set_len;
    logic                 set_dropped;
    sorted_result_t       expected_sorted [$];

    int mismatches;
    int requests_sent;
    int sets_closed;
    int overflow_sets;
    int results_seen;

    stim_row_t directed_rows [0:17] = '{
        '{VAL_MAX, 1'b1, 1'b1, VAL_MAX},
        '{VAL_MIN, 1'b1, 1'b1, VAL_MIN},
        '{32'sd0,  1'b1, 1'b1, 32'sd0},
        '{-32'sd1, 1'b1, 1'b1, -32'sd1},
        '{32'sd5,  1'b0, 1'b0, 32'sd0},
        '{VAL_MIN, 1'b0, 1'b0, 32'sd0},
        '{VAL_MAX, 1'b0, 1'b0, 32'sd0},
        '{32'sd5,  1'b0, 1'b0, 32'sd0},
        '{-32'sd1, 1'b0, 1'b0, 32'sd0},
        '{32'sd0,  1'b1, 1'b0, 32'sd0},
        '{32'sd4,  1'b0, 1'b0, 32'sd0},
        '{32'sd3,  1'b0, 1'b0, 32'sd0},
        '{32'sd2,  1'b0, 1'b0, 32'sd0},
        '{32'sd1,  1'b1, 1'b0, 32'sd0},
        '{VAL_MAX, 1'b0, 1'b0, 32'sd0},
        '{VAL_MIN, 1'b1, 1'b0, 32'sd0},
        '{32'sd7,  1'b0, 1'b0, 32'sd0},
        '{32'sd7,  1'b1, 1'b0, 32'sd0}
    };

    heap_sort_engine #(
        .MAX_ITEMS(STORE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .overflow     (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // store one accepted element; on close, queue the set in ascending order
    task automatic predict_sorted(input logic signed [DW-1:0] v, input logic l);
        int                   i;
        int                   j;
        logic signed [DW-1:0] key;
        if (set_len < STORE_DEPTH)
        begin
            set_vals[set_len] = v;
            set_len++;
        end
        else
        begin
            set_dropped = 1'b1;
        end
        if (l)
        begin
            for (i = 1; i < set_len; i++)
            begin
                key = set_vals[i];
                j   = i - 1;
                while (j >= 0 && set_vals[j] > key)
                begin
                    set_vals[j+1] = set_vals[j];
                    j--;
                end
                set_vals[j+1] = key;
            end
            for (i = 0; i < set_len; i++)
                expected_sorted.push_back('{set_vals[i], (i == set_len - 1), set_dropped});
            sets_closed++;
            if (set_dropped)
                overflow_sets++;
            set_len     = 0;
            set_dropped = 1'b0;
        end
    endtask

    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 20);
        else
            return $urandom_range(30, 300);
    endfunction

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3:    return $signed($urandom_range(0, 8)) - 4;
            4:       return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic int pick_set_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        else if (r < 85)
            return $urandom_range(9, 24);
        else if (r < 95)
            return $urandom_range(25, STORE_DEPTH);
        else
            return $urandom_range(STORE_DEPTH - 1, STORE_DEPTH + 6);
    endfunction

    // present one request after an optional idle stretch and wait for acceptance
    task automatic drive_request(input logic signed [DW-1:0] v, input logic l, input int gap);
        int i;
        if (gap > 0)
        begin
            start <= 1'b0;
            value <= $signed($urandom);
            last  <= 1'($urandom_range(0, 1));
            for (i = 0; i < gap; i++)
                @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        last  <= l;
        @(posedge clk);
        while (busy_seen !== 1'b0)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_random_set(input int len, input bit burst);
        int                   k;
        logic signed [DW-1:0] v;
        for (k = 0; k < len; k++)
        begin
            v = pick_value();
            drive_request(v, (k == len - 1), pick_gap(burst));
            predict_sorted(v, (k == len - 1));
        end
    endtask

    always @(negedge clk)
    begin
        sorted_result_t want;
        busy_seen = busy;
        if (rst_n && result_valid !== 1'b0)
        begin
            if (expected_sorted.size() == 0)
            begin
                flag_mismatch($sformatf("result %0d with no request pending", sorted_value));
            end
            else
            begin
                want = expected_sorted.pop_front();
                results_seen++;
                if (sorted_value !== want.sorted_value)
                    flag_mismatch($sformatf("sorted_value %0d, expected %0d",
                                            sorted_value, want.sorted_value));
                if (final_res !== want.final_res)
                    flag_mismatch($sformatf("final_res %b, expected %b",
                                            final_res, want.final_res));
                if (overflow !== want.overflow)
                    flag_mismatch($sformatf("overflow %b, expected %b",
                                            overflow, want.overflow));
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", expected_sorted.size());
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int  r;
        bit  burst;
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        value         = '0;
        last          = 1'b0;
        busy_seen     = 1'b1;
        set_len       = 0;
        set_dropped   = 1'b0;
        mismatches    = 0;
        requests_sent = 0;
        sets_closed   = 0;
        overflow_sets = 0;
        results_seen  = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < $size(directed_rows); r++)
        begin
            drive_request(directed_rows[r].v, directed_rows[r].l, pick_gap(1'b0));
            if (directed_rows[r].pinned)
            begin
                // single-element set: comes back unchanged
                expected_sorted.push_back('{directed_rows[r].exp_v, 1'b1, 1'b0});
                sets_closed++;
            end
            else
            begin
                predict_sorted(directed_rows[r].v, directed_rows[r].l);
            end
        end

        // overfilled set (closing element dropped), then an exactly full one, then one overfilled by a single element
        send_random_set(STORE_DEPTH + 2, 1'b0);
        send_random_set(STORE_DEPTH, 1'b1);
        send_random_set(STORE_DEPTH + 1, 1'b0);

        while (requests_sent < 480)
        begin
            burst = ($urandom_range(0, 3) == 0);
            send_random_set(pick_set_len(), burst);
        end

        start <= 1'b0;
        while (expected_sorted.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d requests in %0d sets (%0d overflowed), %0d sorted results checked",
                 requests_sent, sets_closed, overflow_sets, results_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/hse_pkg.sv
rtl/hse_mem.sv
rtl/hse_ctrl.sv
rtl/heap_sort_engine.sv
tb/tb.sv
